@@ rtl/pitt_pkg.sv @@
package pitt_pkg;

  localparam int COORD_W     = 20;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MB_W        = COORD_W + 2;
  localparam int PROD_W      = DIFF_W + MB_W;
  localparam int MINOR_W     = 2 * COORD_W + 3;
  localparam int SPLIT_W     = DIFF_W;
  localparam int ACC_W       = 3 * COORD_W + 6;
  localparam int TOL_W       = 16;
  localparam int CMP_W       = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;
  localparam int NUM_AXES    = 3;
  localparam int NUM_VEC     = 12;
  localparam int NUM_MINOR   = 9;
  localparam int MINOR_STEPS = 2 * NUM_MINOR;
  localparam int NUM_STEPS   = MINOR_STEPS + 24;
  localparam int STEP_W      = 6;
  localparam int IDX_W       = 4;
  localparam int DET_MAIN    = 0;
  localparam int DET_LAST    = 3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOL = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [1:0]                vertex_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic inside_res;
    logic coincident;
    logic degenerate;
  } rsp_t;

  typedef enum logic [1:0] {TOT_HOLD, TOT_ADD, TOT_SUB} tot_op_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             wide;
    logic             hi;
    logic             first;
    logic             neg;
    tot_op_t          tot_op;
    logic             last;
    logic             det;
    logic [IDX_W-1:0] tgt;
  } step_ctl_t;

  // Operand vector layout: e1 at 0..2, e2 at 3..5, e3 at 6..8, p at 9..11.
  // Minors: e2 x e3 at 0..2, e3 x e1 at 3..5, e1 x e2 at 6..8.
  function automatic step_ctl_t step_decode(input logic [STEP_W-1:0] step);
    step_ctl_t        c;
    logic [3:0]       j;
    logic [1:0]       axis;
    logic [1:0]       ax1;
    logic [1:0]       ax2;
    logic [1:0]       k;
    logic [STEP_W-1:0] w;
    logic [STEP_W-1:0] base;
    logic [2:0]       r;
    logic [IDX_W-1:0] ub;
    logic [IDX_W-1:0] vb;
    logic [IDX_W-1:0] xb;
    logic [IDX_W-1:0] mb;
    c = '0;
    c.valid = 1'b1;
    if (step < STEP_W'(MINOR_STEPS)) begin
      j = step[4:1];
      case (j)
        4'd0: begin ub = IDX_W'(3); vb = IDX_W'(6); axis = 2'd0; end
        4'd1: begin ub = IDX_W'(3); vb = IDX_W'(6); axis = 2'd1; end
        4'd2: begin ub = IDX_W'(3); vb = IDX_W'(6); axis = 2'd2; end
        4'd3: begin ub = IDX_W'(6); vb = IDX_W'(0); axis = 2'd0; end
        4'd4: begin ub = IDX_W'(6); vb = IDX_W'(0); axis = 2'd1; end
        4'd5: begin ub = IDX_W'(6); vb = IDX_W'(0); axis = 2'd2; end
        4'd6: begin ub = IDX_W'(0); vb = IDX_W'(3); axis = 2'd0; end
        4'd7: begin ub = IDX_W'(0); vb = IDX_W'(3); axis = 2'd1; end
        default: begin ub = IDX_W'(0); vb = IDX_W'(3); axis = 2'd2; end
      endcase
      case (axis)
        2'd0: begin ax1 = 2'd1; ax2 = 2'd2; end
        2'd1: begin ax1 = 2'd2; ax2 = 2'd0; end
        default: begin ax1 = 2'd0; ax2 = 2'd1; end
      endcase
      c.a_idx  = step[0] ? ub + IDX_W'(ax2) : ub + IDX_W'(ax1);
      c.b_idx  = step[0] ? vb + IDX_W'(ax1) : vb + IDX_W'(ax2);
      c.first  = ~step[0];
      c.neg    = step[0];
      c.last   = step[0];
      c.tgt    = j;
      c.tot_op = TOT_HOLD;
    end else begin
      w = step - STEP_W'(MINOR_STEPS);
      if (w < STEP_W'(6)) begin
        k = 2'd0; base = STEP_W'(0);
      end else if (w < STEP_W'(12)) begin
        k = 2'd1; base = STEP_W'(6);
      end else if (w < STEP_W'(18)) begin
        k = 2'd2; base = STEP_W'(12);
      end else begin
        k = 2'd3; base = STEP_W'(18);
      end
      r = 3'(w - base);
      case (k)
        2'd0: begin xb = IDX_W'(0); mb = IDX_W'(0); end
        2'd1: begin xb = IDX_W'(9); mb = IDX_W'(0); end
        2'd2: begin xb = IDX_W'(9); mb = IDX_W'(3); end
        default: begin xb = IDX_W'(9); mb = IDX_W'(6); end
      endcase
      c.a_idx  = xb + IDX_W'(r[2:1]);
      c.b_idx  = mb + IDX_W'(r[2:1]);
      c.wide   = 1'b1;
      c.hi     = r[0];
      c.first  = (r == 3'd0);
      c.last   = (r == 3'd5);
      c.det    = 1'b1;
      c.tgt    = IDX_W'(k);
      c.tot_op = (k == 2'd0) ? TOT_ADD : TOT_SUB;
    end
    return c;
  endfunction

endpackage

@@ rtl/pitt_near.sv @@
module pitt_near (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pitt_pkg::COORD_W-1:0]  point [pitt_pkg::NUM_AXES],
  input  logic signed [pitt_pkg::COORD_W-1:0]  corners [pitt_pkg::NUM_VEC],
  input  logic [pitt_pkg::TOL_W-1:0]           tol,
  output logic                                 coinc
);

  typedef enum logic {N_IDLE, N_RUN} near_state_t;

  near_state_t                        state;
  logic [1:0]                         corner;
  logic [1:0]                         axis;
  logic                               all_near;
  logic [pitt_pkg::IDX_W-1:0]         idx;
  logic signed [pitt_pkg::DIFF_W-1:0] diff;
  logic [pitt_pkg::DIFF_W-1:0]        mag;
  logic                               hit;

  always_comb begin
    idx  = pitt_pkg::IDX_W'({corner, 1'b0}) + pitt_pkg::IDX_W'(corner)
         + pitt_pkg::IDX_W'(axis);
    diff = pitt_pkg::DIFF_W'(point[axis]) - pitt_pkg::DIFF_W'(corners[idx]);
    mag  = diff[pitt_pkg::DIFF_W-1] ? -diff : diff;
    hit  = pitt_pkg::CMP_W'(mag) < pitt_pkg::CMP_W'(tol);
  end

  // One axis of one corner per cycle; a corner matches when all three axes hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= N_IDLE;
      corner   <= '0;
      axis     <= '0;
      all_near <= 1'b0;
      coinc    <= 1'b0;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            state    <= N_RUN;
            corner   <= '0;
            axis     <= '0;
            all_near <= 1'b1;
            coinc    <= 1'b0;
          end
        end
        N_RUN: begin
          if (axis == 2'd2) begin
            if (all_near && hit) begin
              coinc <= 1'b1;
            end
            all_near <= 1'b1;
            axis     <= '0;
            corner   <= corner + 2'd1;
            if (corner == 2'd3) begin
              state <= N_IDLE;
            end
          end else begin
            all_near <= all_near & hit;
            axis     <= axis + 2'd1;
          end
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/pitt_mac.sv @@
module pitt_mac (
  input  logic                                clk,
  input  logic                                clear,
  input  pitt_pkg::step_ctl_t                 acc_step,
  input  logic signed [pitt_pkg::DIFF_W-1:0]  op_a,
  input  logic signed [pitt_pkg::MB_W-1:0]    op_b,
  output logic signed [pitt_pkg::ACC_W-1:0]   acc,
  output logic signed [pitt_pkg::ACC_W-1:0]   tot
);

  logic signed [pitt_pkg::PROD_W-1:0] prod;
  logic signed [pitt_pkg::ACC_W-1:0]  term;
  logic signed [pitt_pkg::ACC_W-1:0]  delta;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // The upper half of a split minor carries the weight of the lower half's width.
  always_comb begin
    term = pitt_pkg::ACC_W'(prod);
    if (acc_step.hi) begin
      term = term <<< pitt_pkg::SPLIT_W;
    end
    delta = acc_step.neg ? -term : term;
  end

  // tot collects D - D1 - D2 - D3 alongside the per-determinant sums.
  always_ff @(posedge clk) begin
    if (acc_step.valid) begin
      acc <= acc_step.first ? delta : acc + delta;
    end
    if (clear) begin
      tot <= '0;
    end else if (acc_step.valid) begin
      case (acc_step.tot_op)
        pitt_pkg::TOT_ADD: tot <= tot + delta;
        pitt_pkg::TOT_SUB: tot <= tot - delta;
        default:           tot <= tot;
      endcase
    end
  end

endmodule

@@ rtl/pitt_seq.sv @@
module pitt_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output pitt_pkg::step_ctl_t issue_step,
  output pitt_pkg::step_ctl_t acc_step,
  output pitt_pkg::step_ctl_t cap_step,
  output logic                busy
);

  typedef enum logic {S_IDLE, S_RUN} seq_state_t;

  seq_state_t                  state;
  logic [pitt_pkg::STEP_W-1:0] step;

  always_comb begin
    issue_step       = pitt_pkg::step_decode(step);
    issue_step.valid = (state == S_RUN);
    busy             = (state == S_RUN) | acc_step.valid | cap_step.valid;
  end

  // Control follows the data: issue, then accumulate, then capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      acc_step <= '0;
      cap_step <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            step  <= '0;
          end
        end
        S_RUN: begin
          if (step == pitt_pkg::STEP_W'(pitt_pkg::NUM_STEPS - 1)) begin
            state <= S_IDLE;
            step  <= '0;
          end else begin
            step <= step + pitt_pkg::STEP_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      acc_step <= issue_step;
      cap_step <= acc_step;
    end
  end

endmodule

@@ rtl/point_in_tetrahedron_test_unit.sv @@
// Corner loads are stored as they are accepted and give no result.
// A point test presents its result once its last determinant is captured, and no
// further request is taken while the test runs; a test makes 42 passes through the
// single 21x22-bit multiplier, its product and sum stages, and the result capture.
// A second result waiting behind a stalled output stalls requests. Reset clears the
// handshake, sequencer and tolerance (to 1); stored corners hold no value until loaded.
module point_in_tetrahedron_test_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  pitt_pkg::req_t                 req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output pitt_pkg::rsp_t                 rsp_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pitt_pkg::PADDR_W-1:0]   paddr,
  input  logic [pitt_pkg::PDATA_W-1:0]   pwdata,
  output logic [pitt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [pitt_pkg::TOL_W-1:0]          tol;
  logic                                reg_idx;
  logic                                cfg_wr;

  logic signed [pitt_pkg::COORD_W-1:0] corners [pitt_pkg::NUM_VEC];
  logic signed [pitt_pkg::COORD_W-1:0] req_pt [pitt_pkg::NUM_AXES];
  logic signed [pitt_pkg::COORD_W-1:0] pt [pitt_pkg::NUM_AXES];
  logic signed [pitt_pkg::DIFF_W-1:0]  vec [pitt_pkg::NUM_VEC];
  logic signed [pitt_pkg::MINOR_W-1:0] minors [pitt_pkg::NUM_MINOR];

  logic                                req_acc;
  logic                                load_acc;
  logic                                test_acc;

  pitt_pkg::step_ctl_t                 issue_step;
  pitt_pkg::step_ctl_t                 acc_step;
  pitt_pkg::step_ctl_t                 cap_step;
  logic                                busy;

  logic signed [pitt_pkg::DIFF_W-1:0]  op_a;
  logic signed [pitt_pkg::MB_W-1:0]    op_b;
  logic signed [pitt_pkg::MINOR_W-1:0] minor_sel;
  logic signed [pitt_pkg::ACC_W-1:0]   acc;
  logic signed [pitt_pkg::ACC_W-1:0]   tot;

  logic                                coinc;
  logic                                d_neg;
  logic                                d_zero;
  logic                                all_pos;
  logic                                done;
  pitt_pkg::rsp_t                      fin;

  pitt_pkg::rsp_t                      pend;
  logic                                pend_valid;
  logic                                out_free;
  logic                                rsp_from_fin;
  logic                                rsp_from_pend;
  logic                                pend_load;

  function automatic logic is_pos(input logic signed [pitt_pkg::ACC_W-1:0] v,
                                  input logic neg);
    return neg ? (v < 0) : (v > 0);
  endfunction

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[pitt_pkg::PADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == pitt_pkg::REG_TOL) ? pitt_pkg::PDATA_W'(tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= pitt_pkg::TOL_RESET;
    end else if (cfg_wr && reg_idx == pitt_pkg::REG_TOL) begin
      tol <= pwdata[pitt_pkg::TOL_W-1:0];
    end
  end

  // Request side.
  assign req_pt[0] = req_data.coord_x;
  assign req_pt[1] = req_data.coord_y;
  assign req_pt[2] = req_data.coord_z;
  assign req_stall = busy | pend_valid;
  assign req_acc   = req_valid & ~req_stall;
  assign load_acc  = req_acc & (req_data.command == pitt_pkg::CMD_LOAD);
  assign test_acc  = req_acc & (req_data.command == pitt_pkg::CMD_TEST);

  always_ff @(posedge clk) begin
    for (int i = 0; i < pitt_pkg::NUM_VEC; i++) begin
      if (load_acc && req_data.vertex_slot == 2'(i / 3)) begin
        corners[i] <= req_pt[2'(i % 3)];
      end
    end
    // Edge vectors and the point relative to corner 0 are fixed for the whole test.
    if (test_acc) begin
      for (int a = 0; a < pitt_pkg::NUM_AXES; a++) begin
        pt[a]      <= req_pt[a];
        vec[a]     <= pitt_pkg::DIFF_W'(corners[3 + a]) - pitt_pkg::DIFF_W'(corners[a]);
        vec[3 + a] <= pitt_pkg::DIFF_W'(corners[6 + a]) - pitt_pkg::DIFF_W'(corners[a]);
        vec[6 + a] <= pitt_pkg::DIFF_W'(corners[9 + a]) - pitt_pkg::DIFF_W'(corners[a]);
        vec[9 + a] <= pitt_pkg::DIFF_W'(req_pt[a]) - pitt_pkg::DIFF_W'(corners[a]);
      end
    end
  end

  pitt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (test_acc),
    .issue_step (issue_step),
    .acc_step   (acc_step),
    .cap_step   (cap_step),
    .busy       (busy)
  );

  pitt_near u_near (
    .clk     (clk),
    .rst     (rst),
    .start   (test_acc),
    .point   (pt),
    .corners (corners),
    .tol     (tol),
    .coinc   (coinc)
  );

  // A minor enters the multiplier in two passes: low part unsigned, high part signed.
  always_comb begin
    op_a      = vec[issue_step.a_idx];
    minor_sel = minors[issue_step.b_idx];
    if (issue_step.wide) begin
      if (issue_step.hi) begin
        op_b = pitt_pkg::MB_W'(minor_sel >>> pitt_pkg::SPLIT_W);
      end else begin
        op_b = $signed({1'b0, minor_sel[pitt_pkg::SPLIT_W-1:0]});
      end
    end else begin
      op_b = pitt_pkg::MB_W'(vec[issue_step.b_idx]);
    end
  end

  pitt_mac u_mac (
    .clk      (clk),
    .clear    (test_acc),
    .acc_step (acc_step),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc      (acc),
    .tot      (tot)
  );

  assign done = cap_step.valid & cap_step.last & cap_step.det &
                (cap_step.tgt == pitt_pkg::IDX_W'(pitt_pkg::DET_LAST));

  always_comb begin
    fin.inside_res = ~coinc & ~d_zero & all_pos & is_pos(acc, d_neg) & is_pos(tot, d_neg);
    fin.coincident = coinc;
    fin.degenerate = d_zero;
  end

  always_ff @(posedge clk) begin
    if (cap_step.valid && cap_step.last) begin
      if (!cap_step.det) begin
        minors[cap_step.tgt] <= acc[pitt_pkg::MINOR_W-1:0];
      end else if (cap_step.tgt == pitt_pkg::IDX_W'(pitt_pkg::DET_MAIN)) begin
        d_neg   <= acc < 0;
        d_zero  <= acc == '0;
        all_pos <= 1'b1;
      end else begin
        all_pos <= all_pos & is_pos(acc, d_neg);
      end
    end
  end

  // Result side: a finished result waits in pend while the output register is held.
  assign out_free      = ~rsp_valid | ~rsp_stall;
  assign rsp_from_fin  = done & out_free;
  assign pend_load     = done & ~out_free;
  assign rsp_from_pend = ~done & pend_valid & out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (rsp_from_fin || rsp_from_pend) begin
        rsp_valid <= 1'b1;
      end else if (out_free) begin
        rsp_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (rsp_from_pend) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_from_fin) begin
      rsp_data <= fin;
    end else if (rsp_from_pend) begin
      rsp_data <= pend;
    end
    if (pend_load) begin
      pend <= fin;
    end
  end

`ifndef SYNTHESIS
  a_rsp_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(done) || $past(pend_valid))
    else $error("result raised without a finished test");

  a_pend_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !done)
    else $error("held result overwritten by a new test");

  a_pend_behind_output: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> rsp_valid)
    else $error("held result while output register is empty");

  a_test_starts_seq: assert property (@(posedge clk) disable iff (rst)
    test_acc |=> busy)
    else $error("accepted test did not start the sequencer");
`endif

endmodule

@@ bench/point_in_tetrahedron_test_unit_test.sv @@
module point_in_tetrahedron_test_unit_test;
  import pitt_pkg::*;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned PHASE_ITEMS = 265;
  localparam logic [PADDR_W-1:0] TOL_ADDR = PADDR_W'(4 * int'(REG_TOL));
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Copy of the block's state as seen through accepted requests and tolerance writes.
  logic signed [COORD_W-1:0] model_corners [4][3];
  logic [TOL_W-1:0] model_tol = TOL_RESET;
  rsp_t expected_verdicts [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned test_count = 0;
  int unsigned tol_writes = 0;
  int unsigned seen_inside = 0;
  int unsigned seen_coincident = 0;
  int unsigned seen_degenerate = 0;

  point_in_tetrahedron_test_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic acc_t det3(input acc_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
    acc_t m0, m1, m2;
    m0 = b1 * c2 - b2 * c1;
    m1 = b0 * c2 - b2 * c0;
    m2 = b0 * c1 - b1 * c0;
    return a0 * m0 - a1 * m1 + a2 * m2;
  endfunction

  function automatic rsp_t classify_point(input req_t r);
    acc_t cv [4][3];
    acc_t pv [3];
    acc_t e1 [3];
    acc_t e2 [3];
    acc_t e3 [3];
    acc_t pd [3];
    acc_t lim, gap, d, d1, d2, d3, rest;
    rsp_t v;
    bit near;
    v = '0;
    lim = '0;
    lim[TOL_W-1:0] = model_tol;
    pv[0] = $signed(r.coord_x);
    pv[1] = $signed(r.coord_y);
    pv[2] = $signed(r.coord_z);
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) cv[k][a] = model_corners[k][a];
    end
    for (int k = 0; k < 4; k++) begin
      near = 1'b1;
      for (int a = 0; a < 3; a++) begin
        gap = pv[a] - cv[k][a];
        if (gap < 0) gap = -gap;
        if (gap >= lim) near = 1'b0;
      end
      if (near) v.coincident = 1'b1;
    end
    for (int a = 0; a < 3; a++) begin
      e1[a] = cv[1][a] - cv[0][a];
      e2[a] = cv[2][a] - cv[0][a];
      e3[a] = cv[3][a] - cv[0][a];
      pd[a] = pv[a] - cv[0][a];
    end
    d = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
    v.degenerate = (d == 0);
    if (!v.coincident && !v.degenerate) begin
      d1 = det3(pd[0], pd[1], pd[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
      d2 = det3(e1[0], e1[1], e1[2], pd[0], pd[1], pd[2], e3[0], e3[1], e3[2]);
      d3 = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], pd[0], pd[1], pd[2]);
      rest = d - d1 - d2 - d3;
      // Sign tests against the determinant stand in for the division.
      if (d < 0) begin
        d1 = -d1;
        d2 = -d2;
        d3 = -d3;
        rest = -rest;
      end
      v.inside_res = (d1 > 0) && (d2 > 0) && (d3 > 0) && (rest > 0);
    end
    return v;
  endfunction

  function automatic req_t mk_req(input logic cmd, input int unsigned slot,
                                  input longint x, input longint y, input longint z);
    req_t r;
    r.command = cmd;
    r.vertex_slot = 2'(slot);
    r.coord_x = COORD_W'(x);
    r.coord_y = COORD_W'(y);
    r.coord_z = COORD_W'(z);
    return r;
  endfunction

  function automatic dir_row_t mk_row(input req_t rq, input bit typed,
                                      input bit ins, input bit coi, input bit deg);
    dir_row_t row;
    row.rq = rq;
    row.typed = typed;
    row.want.inside_res = ins;
    row.want.coincident = coi;
    row.want.degenerate = deg;
    return row;
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint wrap_coord(input longint v);
    logic signed [COORD_W-1:0] t;
    t = v[COORD_W-1:0];
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] got,
                                 input logic [2:0] want);
    $display("mismatch at cycle %0d: %s got %b expected %b", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic note_accepted(input req_t r, input bit typed, input rsp_t want);
    rsp_t verdict;
    if (r.command == CMD_LOAD) begin
      model_corners[r.vertex_slot][0] = r.coord_x;
      model_corners[r.vertex_slot][1] = r.coord_y;
      model_corners[r.vertex_slot][2] = r.coord_z;
    end else begin
      verdict = typed ? want : classify_point(r);
      expected_verdicts = {expected_verdicts, verdict};
      test_count++;
    end
  endtask

  // Valid stays high from one request to the next unless an idle gap is drawn.
  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    note_accepted(r, typed, want);
    sent_count++;
  endtask

  task automatic drain_block();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TOL_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_tol = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_writes++;
  endtask

  // One tetrahedron load followed by a burst of point tests, with some noise.
  task automatic random_episode();
    longint gc [4][3];
    longint ctr [3];
    longint pt [3];
    longint w [4];
    longint span, wsum, acc, reach;
    int unsigned start, n_loads, n_tests, kind, pk, pj;
    bit flat;
    case ($urandom_range(3))
      0: span = 64;
      1: span = 2048;
      2: span = 65536;
      default: span = COORD_MAX;
    endcase
    for (int a = 0; a < 3; a++) begin
      ctr[a] = (span == COORD_MAX) ? 0 : rand_between(COORD_MIN + span, COORD_MAX - span);
    end
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) gc[k][a] = wrap_coord(ctr[a] + rand_between(-span, span));
    end
    if ($urandom_range(7) == 0) begin
      flat = $urandom_range(1);
      pk = $urandom_range(2);
      for (int a = 0; a < 3; a++) begin
        gc[3][a] = flat ? wrap_coord(gc[1][a] + gc[2][a] - gc[0][a]) : gc[pk][a];
      end
    end
    start = $urandom_range(3);
    n_loads = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 4;
    for (int j = 0; j < n_loads; j++) begin
      pk = (start + j) % 4;
      send_request(mk_req(CMD_LOAD, pk, gc[pk][0], gc[pk][1], gc[pk][2]), 1'b0, '0);
    end
    n_tests = $urandom_range(1, 8);
    for (int j = 0; j < n_tests; j++) begin
      if ($urandom_range(15) == 0) begin
        send_request(mk_req(CMD_LOAD, $urandom_range(3), rand_between(COORD_MIN, COORD_MAX),
                            rand_between(COORD_MIN, COORD_MAX),
                            rand_between(COORD_MIN, COORD_MAX)), 1'b0, '0);
      end
      kind = $urandom_range(9);
      pk = $urandom_range(3);
      pj = (pk + 1 + $urandom_range(2)) % 4;
      reach = (model_tol > 2999) ? 3000 : longint'(model_tol) + 1;
      wsum = 0;
      for (int k = 0; k < 4; k++) begin
        w[k] = $urandom_range(1, 100);
        wsum += w[k];
      end
      for (int a = 0; a < 3; a++) begin
        case (kind)
          0, 1, 2, 3: begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += w[k] * gc[k][a];
            pt[a] = acc / wsum;
          end
          4, 5: pt[a] = gc[pk][a] + rand_between(-reach, reach);
          6: pt[a] = (gc[pk][a] + gc[pj][a]) / 2;
          7: pt[a] = ctr[a] + rand_between(-span, span);
          8: pt[a] = rand_between(COORD_MIN, COORD_MAX);
          default: pt[a] = gc[pk][a];
        endcase
      end
      send_request(mk_req(CMD_TEST, $urandom_range(3), pt[0], pt[1], pt[2]), 1'b0, '0);
    end
  endtask

  // Receiver: checks each accepted result and draws the next stall.
  always @(posedge clk) begin : rsp_side
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no request waiting", rsp_data, 3'b000);
      end else begin
        want = expected_verdicts.pop_front();
        if (rsp_data.inside_res !== want.inside_res)
          report_mismatch("inside_res", rsp_data.inside_res, want.inside_res);
        if (rsp_data.coincident !== want.coincident)
          report_mismatch("coincident", rsp_data.coincident, want.coincident);
        if (rsp_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
        seen_inside += want.inside_res;
        seen_coincident += want.coincident;
        seen_degenerate += want.degenerate;
      end
    end
    rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, started on demand from the stimulus process.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_taken + 1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    dir_row_t plan [$];
    logic [TOL_W-1:0] tol_pick;
    int unsigned target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unit tetrahedron, one unit being 256 in Q12.8.
    plan = {plan, mk_row(mk_req(CMD_LOAD, 0, 0, 0, 0), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 1, 256, 0, 0), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 2, 0, 256, 0), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 3, 0, 0, 256), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 0, 0, 0), 1, 0, 1, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 3, 32, 32, 32), 1, 1, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 1, COORD_MIN, COORD_MIN, COORD_MIN), 1, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 2, COORD_MAX, COORD_MAX, COORD_MAX), 1, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 256, 0, 0), 1, 0, 1, 0)};
    // A distance equal to the tolerance does not count as matching a corner.
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 1, 0, 0), 1, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 3, 64, 64, 128), 1, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 85, 85, 85), 1, 1, 0, 0)};
    // Flat tetrahedron: zero determinant, with and without a coincident point.
    plan = {plan, mk_row(mk_req(CMD_LOAD, 3, 128, 128, 0), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 10, 10, 0), 1, 0, 0, 1)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 0, 128, 128, 0), 1, 0, 1, 1)};
    // Mirrored corner gives a negative determinant.
    plan = {plan, mk_row(mk_req(CMD_LOAD, 3, 0, 0, -256), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 2, 32, 32, -32), 1, 1, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 2, 32, 32, 32), 1, 0, 0, 0)};
    // Corners at the coordinate extremes stress the product widths.
    plan = {plan, mk_row(mk_req(CMD_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MIN), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 1, COORD_MAX, COORD_MIN, COORD_MIN), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 2, COORD_MIN, COORD_MAX, COORD_MIN), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_LOAD, 3, COORD_MIN, COORD_MIN, COORD_MAX), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 1, 0, 0, 0), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 1, -262144, -262144, -262144), 0, 0, 0, 0)};
    plan = {plan, mk_row(mk_req(CMD_TEST, 3, COORD_MAX, COORD_MIN, COORD_MIN), 1, 0, 1, 0)};
    foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].want);
    drain_block();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin tol_pick = '0; send_idle_pct = 0; stall_pct = 0; end
        1: begin tol_pick = '1; send_idle_pct = 80; stall_pct = 0; end
        2: begin tol_pick = TOL_W'($urandom_range(1, 600)); send_idle_pct = 0; stall_pct = 80; end
        3: begin tol_pick = TOL_RESET; send_idle_pct = 7; stall_pct = 7; end
        default: begin tol_pick = TOL_W'($urandom_range(65535)); send_idle_pct = 0;
          stall_pct = 0; end
      endcase
      write_tolerance(tol_pick);
      // The receiver holds off while requests keep coming, so the input backs up.
      if (ph == 3) hold_asked++;
      target = 25 + (ph + 1) * PHASE_ITEMS;
      while (sent_count < target) random_episode();
      drain_block();
    end

    $display("Covered %0d requests, %0d of them point tests, under %0d tolerance writes.",
             sent_count, test_count, tol_writes);
    $display("Verdicts: %0d inside, %0d coincident, %0d degenerate, with stalls and a hold-off.",
             seen_inside, seen_coincident, seen_degenerate);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ point_in_tetrahedron_test_unit.f @@
rtl/pitt_pkg.sv
rtl/pitt_near.sv
rtl/pitt_mac.sv
rtl/pitt_seq.sv
rtl/point_in_tetrahedron_test_unit.sv
bench/point_in_tetrahedron_test_unit_test.sv
